[design/doid_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doid_pkg
// Shared types, codes and constants of the DER object identifier decoder.
// ----------------------------------------------------------------------------
package doid_pkg;

    localparam int ARC_DIGITS_DEF  = 10;
    localparam int ACC_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Digit position index; covers every accumulator width up to 64 bits.
    localparam int POS_W = 5;

    localparam int CLEN_W = 32;

    localparam logic [7:0] TAG_RESET = 8'h06;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_DOT  = 8'h2e;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WRONG_TAG = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_LEN_LONG  = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_UNTERM    = 3'd5;

    // Command kinds passed from the parser to the text generator.
    localparam logic [1:0] K_ERR  = 2'd0;  // single error beat
    localparam logic [1:0] K_PAIR = 2'd1;  // digit, '.', number (first two arcs)
    localparam logic [1:0] K_ARC  = 2'd2;  // '.', number

    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       status;
        logic [2:0]       quot;
        logic [POS_W-1:0] start;
        logic             last;
    } t_cmd_ctl;

    // Decimal digits of the largest value of a w-bit word. The factor
    // slightly overestimates log10(2), so the count never falls short.
    function automatic int dec_positions(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

endpackage
`default_nettype wire

[design/doid_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doid_in_if
// Byte channel into the decoder: one buffer byte per beat with its marks.
// ----------------------------------------------------------------------------
interface doid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface
`default_nettype wire

[design/doid_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doid_out_if
// Character channel out of the decoder: one ASCII character per beat.
// ----------------------------------------------------------------------------
interface doid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;
    logic [2:0] status;

    modport source (output valid, output out_char, output out_last,
                    output status, input ready);
    modport sink   (input valid, input out_char, input out_last,
                    input status, output ready);
endinterface
`default_nettype wire

[design/doid_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doid_front
// Byte parser: tag check, length decode, base-128 sub-identifier build.
// Each accepted byte pushes at most one command into the queue.
// ----------------------------------------------------------------------------
module doid_front #(
    parameter int ACC_WIDTH = doid_pkg::ACC_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [7:0]              i_cfg_data,
    doid_in_if.sink                i_in,
    input  wire                    i_full,
    output logic                   o_push,
    output doid_pkg::t_cmd_ctl     o_ctl,
    output logic [ACC_WIDTH-1:0]   o_val
);
    import doid_pkg::*;

    localparam int NPOS   = dec_positions(ACC_WIDTH);
    localparam int NB_MAX = (ACC_WIDTH + 6) / 7;
    localparam int NBW    = $clog2(NB_MAX + 1);
    localparam int NB_TAB = 2 ** NBW;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_LONGLEN = 3'd2;
    localparam logic [2:0] PH_CONTENT = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    typedef logic [NB_TAB-1:0][POS_W-1:0] t_start_tab;

    // Highest decimal position a sub-identifier of n base-128 bytes can reach.
    function automatic t_start_tab gen_start();
        t_start_tab tab;
        int         v;
        for (int i = 0; i < NB_TAB; i++) begin
            v = (7 * i * 30103) / 100000;
            if (v > NPOS - 1) begin
                v = NPOS - 1;
            end
            tab[i] = POS_W'(v);
        end
        return tab;
    endfunction

    localparam t_start_tab START_TAB = gen_start();

    function automatic t_cmd_ctl err_cmd(input logic [2:0] st);
        t_cmd_ctl c;
        c        = '0;
        c.kind   = K_ERR;
        c.status = st;
        c.last   = 1'b1;
        return c;
    endfunction

    logic [7:0]           r_tag;
    logic [2:0]           r_phase, n_phase;
    logic [2:0]           r_len_left, n_len_left;
    logic [CLEN_W-1:0]    r_content, n_content;
    logic [ACC_WIDTH-1:0] r_acc, n_acc;
    logic                 r_first_content, n_first_content;
    logic [NBW-1:0]       r_nb, n_nb;

    logic                 w_accept;
    logic [7:0]           w_b;
    logic [ACC_WIDTH-1:0] w_acc_next;
    logic [NBW-1:0]       w_nb_now;
    logic [2:0]           w_quot;
    logic [7:0]           w_quot40;
    logic [7:0]           w_rem;
    logic [CLEN_W-1:0]    w_content_dec;
    logic [CLEN_W-1:0]    w_cat;
    logic [2:0]           w_len_dec;
    logic                 w_len_done;
    logic [CLEN_W-1:0]    w_len_val;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign w_b        = i_in.data_byte;

    // Shifted-in seven bits land on zeros, so the add is a concatenation.
    assign w_acc_next    = {r_acc[ACC_WIDTH-8:0], w_b[6:0]};
    assign w_nb_now      = (r_nb == NBW'(NB_MAX)) ? r_nb : r_nb + 1'b1;
    assign w_content_dec = r_content - 1'b1;
    assign w_cat         = {r_content[CLEN_W-9:0], w_b};
    assign w_len_dec     = r_len_left - 1'b1;

    always_comb begin
        priority if (w_b >= 8'd240) begin
            w_quot = 3'd6;
        end else if (w_b >= 8'd200) begin
            w_quot = 3'd5;
        end else if (w_b >= 8'd160) begin
            w_quot = 3'd4;
        end else if (w_b >= 8'd120) begin
            w_quot = 3'd3;
        end else if (w_b >= 8'd80) begin
            w_quot = 3'd2;
        end else if (w_b >= 8'd40) begin
            w_quot = 3'd1;
        end else begin
            w_quot = 3'd0;
        end
    end

    assign w_quot40 = 8'({5'b0, w_quot} * 8'd40);
    assign w_rem    = w_b - w_quot40;

    always_comb begin
        n_phase         = r_phase;
        n_len_left      = r_len_left;
        n_content       = r_content;
        n_acc           = r_acc;
        n_first_content = r_first_content;
        n_nb            = r_nb;
        o_push          = 1'b0;
        o_ctl           = '0;
        o_val           = '0;
        w_len_done      = 1'b0;
        w_len_val       = '0;

        if (w_accept) begin
            if (i_in.first_byte) begin
                n_len_left      = '0;
                n_content       = '0;
                n_acc           = '0;
                n_first_content = 1'b1;
                n_nb            = '0;
                if (w_b != r_tag) begin
                    o_push  = 1'b1;
                    o_ctl   = err_cmd(ST_WRONG_TAG);
                    n_phase = PH_DONE;
                end else if (i_in.last_byte) begin
                    o_push  = 1'b1;
                    o_ctl   = err_cmd(ST_TRUNC);
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_LEN;
                end
            end else begin
                unique case (r_phase)
                    PH_LEN: begin
                        if (w_b[7]) begin
                            if (w_b[6:0] > 7'd4) begin
                                o_push  = 1'b1;
                                o_ctl   = err_cmd(ST_LEN_LONG);
                                n_phase = PH_DONE;
                            end else if (w_b[6:0] == 7'd0) begin
                                w_len_done = 1'b1;
                            end else begin
                                n_content  = '0;
                                n_len_left = w_b[2:0];
                                if (i_in.last_byte) begin
                                    o_push  = 1'b1;
                                    o_ctl   = err_cmd(ST_TRUNC);
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_LONGLEN;
                                end
                            end
                        end else begin
                            w_len_done = 1'b1;
                            w_len_val  = {{(CLEN_W-8){1'b0}}, w_b};
                        end
                    end
                    PH_LONGLEN: begin
                        n_content  = w_cat;
                        n_len_left = w_len_dec;
                        if (w_len_dec == 3'd0) begin
                            w_len_done = 1'b1;
                            w_len_val  = w_cat;
                        end else if (i_in.last_byte) begin
                            o_push  = 1'b1;
                            o_ctl   = err_cmd(ST_TRUNC);
                            n_phase = PH_DONE;
                        end
                    end
                    PH_CONTENT: begin
                        n_content = w_content_dec;
                        if (w_content_dec != '0 && i_in.last_byte) begin
                            o_push  = 1'b1;
                            o_ctl   = err_cmd(ST_TRUNC);
                            n_phase = PH_DONE;
                        end else begin
                            if (r_first_content) begin
                                n_first_content = 1'b0;
                                o_push          = 1'b1;
                                o_ctl.kind      = K_PAIR;
                                o_ctl.status    = ST_OK;
                                o_ctl.quot      = w_quot;
                                o_ctl.start     = POS_W'(1);
                                o_ctl.last      = (w_content_dec == '0);
                                o_val           = ACC_WIDTH'(w_rem);
                            end else if (!w_b[7]) begin
                                o_push       = 1'b1;
                                o_ctl.kind   = K_ARC;
                                o_ctl.status = ST_OK;
                                o_ctl.start  = START_TAB[w_nb_now];
                                o_ctl.last   = (w_content_dec == '0);
                                o_val        = w_acc_next;
                                n_acc        = '0;
                                n_nb         = '0;
                            end else begin
                                n_acc = w_acc_next;
                                n_nb  = w_nb_now;
                                if (w_content_dec == '0) begin
                                    o_push = 1'b1;
                                    o_ctl  = err_cmd(ST_UNTERM);
                                end
                            end
                            if (w_content_dec == '0) begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                if (w_len_done) begin
                    n_content = w_len_val;
                    if (w_len_val < CLEN_W'(2)) begin
                        o_push  = 1'b1;
                        o_ctl   = err_cmd(ST_SHORT);
                        n_phase = PH_DONE;
                    end else if (i_in.last_byte) begin
                        o_push  = 1'b1;
                        o_ctl   = err_cmd(ST_TRUNC);
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_CONTENT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag           <= TAG_RESET;
            r_phase         <= PH_TAG;
            r_len_left      <= '0;
            r_content       <= '0;
            r_acc           <= '0;
            r_first_content <= 1'b1;
            r_nb            <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tag <= i_cfg_data;
            end
            r_phase         <= n_phase;
            r_len_left      <= n_len_left;
            r_content       <= n_content;
            r_acc           <= n_acc;
            r_first_content <= n_first_content;
            r_nb            <= n_nb;
        end
    end

endmodule
`default_nettype wire

[design/doid_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doid_queue
// Short command queue between the byte parser and the text generator.
// ----------------------------------------------------------------------------
module doid_queue #(
    parameter int ACC_WIDTH = doid_pkg::ACC_WIDTH_DEF,
    parameter int DEPTH     = doid_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  doid_pkg::t_cmd_ctl     i_ctl,
    input  wire [ACC_WIDTH-1:0]    i_val,
    input  wire                    i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output doid_pkg::t_cmd_ctl     o_ctl,
    output logic [ACC_WIDTH-1:0]   o_val
);
    import doid_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd_ctl             r_ctl [DEPTH];
    logic [ACC_WIDTH-1:0] r_val [DEPTH];
    logic [PTR_W-1:0]     r_wr, r_rd;
    logic [CNT_W-1:0]     r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_ctl   = r_ctl[r_rd];
    assign o_val   = r_val[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr] <= i_ctl;
            r_val[r_wr] <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[design/doid_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doid_back
// Text generator: turns queued commands into ASCII beats, one decimal digit
// per unstalled cycle, by compare against the multiples of a power of ten.
// ----------------------------------------------------------------------------
module doid_back #(
    parameter int ACC_WIDTH  = doid_pkg::ACC_WIDTH_DEF,
    parameter int ARC_DIGITS = doid_pkg::ARC_DIGITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_empty,
    input  doid_pkg::t_cmd_ctl     i_ctl,
    input  wire [ACC_WIDTH-1:0]    i_val,
    output logic                   o_pop,
    doid_out_if.source             o_out
);
    import doid_pkg::*;

    localparam int NPOS   = dec_positions(ACC_WIDTH);
    localparam int CW     = ACC_WIDTH + 4;
    localparam int NTAB   = 2 ** POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DOT  = 2'd1;
    localparam logic [1:0] S_DIG  = 2'd2;

    typedef logic [NTAB-1:0][9:0][CW-1:0] t_mult_tab;

    // Row p holds k * 10^p for k = 0..9; rows past the top position are unused.
    function automatic t_mult_tab gen_mult();
        t_mult_tab     tab;
        logic [CW-1:0] pw;
        pw = CW'(1);
        for (int p = 0; p < NTAB; p++) begin
            for (int k = 0; k < 10; k++) begin
                tab[p][k] = (p < NPOS) ? CW'(CW'(k) * pw) : '1;
            end
            pw = CW'(pw * CW'(10));
        end
        return tab;
    endfunction

    localparam t_mult_tab MULT = gen_mult();

    logic [1:0]           r_state, n_state;
    logic [ACC_WIDTH-1:0] r_val, n_val;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_started, n_started;
    logic                 r_last, n_last;

    logic                 r_o_valid, n_o_valid;
    logic [7:0]           r_o_char, n_o_char;
    logic                 r_o_last, n_o_last;
    logic [2:0]           r_o_status, n_o_status;

    logic                 w_stall;
    logic [8:0]           w_ge;
    logic [3:0]           w_digit;
    logic [ACC_WIDTH-1:0] w_val_sub;
    logic                 w_show;

    assign o_out.valid    = r_o_valid;
    assign o_out.out_char = r_o_char;
    assign o_out.out_last = r_o_last;
    assign o_out.status   = r_o_status;

    assign w_stall = r_o_valid && !o_out.ready;

    always_comb begin
        for (int k = 1; k < 10; k++) begin
            w_ge[k-1] = ({4'b0, r_val} >= MULT[r_pos][k]);
        end
    end

    assign w_digit   = 4'($countones(w_ge));
    assign w_val_sub = r_val - MULT[r_pos][w_digit][ACC_WIDTH-1:0];

    // Positions above the kept digit count are consumed but not shown; a
    // nonzero digit there still forces the kept zeros out.
    assign w_show = (int'(r_pos) < ARC_DIGITS)
                 && (r_started || (w_digit != 4'd0) || (r_pos == '0));

    always_comb begin
        n_state    = r_state;
        n_val      = r_val;
        n_pos      = r_pos;
        n_started  = r_started;
        n_last     = r_last;
        n_o_valid  = r_o_valid;
        n_o_char   = r_o_char;
        n_o_last   = r_o_last;
        n_o_status = r_o_status;
        o_pop      = 1'b0;

        if (!w_stall) begin
            n_o_valid  = 1'b0;
            n_o_last   = 1'b0;
            n_o_status = ST_OK;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        o_pop     = 1'b1;
                        n_o_valid = 1'b1;
                        n_val     = i_val;
                        n_pos     = i_ctl.start;
                        n_started = 1'b0;
                        n_last    = i_ctl.last;
                        unique case (i_ctl.kind)
                            K_PAIR: begin
                                n_o_char = CHAR_ZERO + {5'b0, i_ctl.quot};
                                n_state  = S_DOT;
                            end
                            K_ARC: begin
                                n_o_char = CHAR_DOT;
                                n_state  = S_DIG;
                            end
                            default: begin
                                n_o_char   = CHAR_NUL;
                                n_o_last   = 1'b1;
                                n_o_status = i_ctl.status;
                            end
                        endcase
                    end
                end
                S_DOT: begin
                    n_o_valid = 1'b1;
                    n_o_char  = CHAR_DOT;
                    n_state   = S_DIG;
                end
                S_DIG: begin
                    n_val     = w_val_sub;
                    n_o_valid = w_show;
                    n_o_char  = CHAR_ZERO + {4'b0, w_digit};
                    n_o_last  = r_last && (r_pos == '0);
                    if (w_digit != 4'd0) begin
                        n_started = 1'b1;
                    end
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_last     <= n_last;
        r_o_char   <= n_o_char;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_o_valid <= n_o_valid;
        end
    end

endmodule
`default_nettype wire

[design/der_oid_to_dotted_decimal.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// der_oid_to_dotted_decimal
// DER object identifier element to dotted decimal ASCII text.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the command queue has room; the text
//   generator sets the sustained rate: it sends an error beat alone, and for
//   a sub-identifier a dot and then one digit step per position it can reach.
// Path: a byte's command enters the queue, then its text the output register.
// Reset: synchronous, active low; parser, queue and output go empty, the
//   expected tag returns to 6. There is no clearing pass.
// ----------------------------------------------------------------------------
module der_oid_to_dotted_decimal #(
    parameter int ARC_DIGITS  = doid_pkg::ARC_DIGITS_DEF,
    parameter int ACC_WIDTH   = doid_pkg::ACC_WIDTH_DEF,
    parameter int QUEUE_DEPTH = doid_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data,
    doid_in_if.sink    i_in,
    doid_out_if.source o_out
);
    import doid_pkg::*;

    logic                 w_push, w_pop, w_full, w_empty;
    t_cmd_ctl             w_push_ctl, w_head_ctl;
    logic [ACC_WIDTH-1:0] w_push_val, w_head_val;

    doid_front #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_ctl      (w_push_ctl),
        .o_val      (w_push_val)
    );

    doid_queue #(
        .ACC_WIDTH (ACC_WIDTH),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ctl   (w_push_ctl),
        .i_val   (w_push_val),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_ctl   (w_head_ctl),
        .o_val   (w_head_val)
    );

    doid_back #(
        .ACC_WIDTH  (ACC_WIDTH),
        .ARC_DIGITS (ARC_DIGITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_ctl   (w_head_ctl),
        .i_val   (w_head_val),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from an empty queue");

    a_error_beat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_OK))
            |-> ((o_out.out_char == CHAR_NUL) && o_out.out_last))
        else $error("error beat without null character or last mark");

    a_mid_beat_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.out_last) |-> (o_out.status == ST_OK))
        else $error("error status on a beat that is not the last");

endmodule
`default_nettype wire

[tb/doid_text_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doid_text_checker
// Watches the byte and character channels of the decoder. It keeps its own
// copy of the parser state and the tag register, works out the dotted text
// that every accepted byte beat must produce, and compares each character
// beat with the oldest expected one.
// ----------------------------------------------------------------------------
module doid_text_checker (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_cfg_we,
    input  wire [7:0] i_cfg_data,
    doid_in_if        i_bytes,
    doid_out_if       i_text,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import doid_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LEN,
        PH_LONGLEN,
        PH_CONTENT,
        PH_DONE
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [2:0] status;
    } t_text_beat;

    t_text_beat   expected_text[$];
    t_parse_phase phase;
    logic [7:0]   tag_reg;
    logic [2:0]   len_bytes_left;
    logic [31:0]  content_left;
    logic [31:0]  arc_acc;
    logic         first_content;
    logic         pending_cont;
    int           fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] text mismatch: %s", $time, what);
    endtask

    task automatic push_char(input logic [7:0] c);
        t_text_beat t;
        t.ch     = c;
        t.last   = 1'b0;
        t.status = ST_OK;
        expected_text.push_back(t);
    endtask

    task automatic push_error(input logic [2:0] st);
        t_text_beat t;
        t.ch     = CHAR_NUL;
        t.last   = 1'b1;
        t.status = st;
        phase    = PH_DONE;
        expected_text.push_back(t);
    endtask

    // Decimal digits of v, most significant first, leading zeros dropped.
    task automatic push_decimal(input logic [31:0] v);
        logic [3:0] digs [ARC_DIGITS_DEF];
        int         k;
        k = 0;
        do begin
            digs[k] = 4'(v % 32'd10);
            v       = v / 32'd10;
            k++;
        end while (v != 0 && k < ARC_DIGITS_DEF);
        while (k > 0) begin
            k--;
            push_char(CHAR_ZERO + 8'(digs[k]));
        end
    endtask

    task automatic length_known(input logic l);
        if (content_left < 32'd2) begin
            push_error(ST_SHORT);
        end else if (l) begin
            push_error(ST_TRUNC);
        end else begin
            phase = PH_CONTENT;
        end
    endtask

    task automatic predict_text(input logic [7:0] b, input logic f, input logic l);
        int         base;
        t_text_beat t;
        base = expected_text.size();
        if (f) begin
            len_bytes_left = '0;
            content_left   = '0;
            arc_acc        = '0;
            first_content  = 1'b1;
            pending_cont   = 1'b0;
            if (b != tag_reg) begin
                push_error(ST_WRONG_TAG);
            end else if (l) begin
                push_error(ST_TRUNC);
            end else begin
                phase = PH_LEN;
            end
        end else begin
            case (phase)
                PH_LEN: begin
                    if (b[7]) begin
                        if (b[6:0] > 7'd4) begin
                            push_error(ST_LEN_LONG);
                        end else begin
                            content_left = '0;
                            if (b[6:0] == 7'd0) begin
                                length_known(l);
                            end else begin
                                len_bytes_left = b[2:0];
                                if (l) begin
                                    push_error(ST_TRUNC);
                                end else begin
                                    phase = PH_LONGLEN;
                                end
                            end
                        end
                    end else begin
                        content_left = {24'd0, b};
                        length_known(l);
                    end
                end
                PH_LONGLEN: begin
                    content_left   = {content_left[23:0], b};
                    len_bytes_left = len_bytes_left - 3'd1;
                    if (len_bytes_left == 3'd0) begin
                        length_known(l);
                    end else if (l) begin
                        push_error(ST_TRUNC);
                    end
                end
                PH_CONTENT: begin
                    content_left = content_left - 32'd1;
                    // A buffer that ends inside the content drops the text
                    // this byte would have finished.
                    if (content_left != 0 && l) begin
                        push_error(ST_TRUNC);
                    end else begin
                        if (first_content) begin
                            first_content = 1'b0;
                            push_decimal(32'(b) / 32'd40);
                            push_char(CHAR_DOT);
                            push_decimal(32'(b) % 32'd40);
                        end else begin
                            arc_acc      = (arc_acc << 7) + {25'd0, b[6:0]};
                            pending_cont = b[7];
                            if (!pending_cont) begin
                                push_char(CHAR_DOT);
                                push_decimal(arc_acc);
                                arc_acc = '0;
                            end
                        end
                        if (content_left == 0) begin
                            phase = PH_DONE;
                            if (pending_cont || expected_text.size() == base) begin
                                push_error(ST_UNTERM);
                            end else begin
                                t      = expected_text.pop_back();
                                t.last = 1'b1;
                                expected_text.push_back(t);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_text_beat(input logic [7:0] c, input logic l, input logic [2:0] st);
        t_text_beat want;
        if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected beat char=%02h last=%0b status=%0d",
                                      c, l, st));
        end else begin
            want = expected_text.pop_front();
            if (c !== want.ch || l !== want.last || st !== want.status) begin
                report_mismatch($sformatf(
                    "char=%02h/%02h last=%0b/%0b status=%0d/%0d (got/expected)",
                    c, want.ch, l, want.last, st, want.status));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase          = PH_TAG;
            tag_reg        = TAG_RESET;
            len_bytes_left = '0;
            content_left   = '0;
            arc_acc        = '0;
            first_content  = 1'b1;
            pending_cont   = 1'b0;
            expected_text.delete();
        end else begin
            if (i_cfg_we) begin
                tag_reg = i_cfg_data;
            end
            if (i_text.valid && i_text.ready) begin
                check_text_beat(i_text.out_char, i_text.out_last, i_text.status);
            end
            if (i_bytes.valid && i_bytes.ready) begin
                predict_text(i_bytes.data_byte, i_bytes.first_byte, i_bytes.last_byte);
            end
        end
        o_pending <= expected_text.size();
    end

endmodule
`default_nettype wire

[tb/der_oid_to_dotted_decimal_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// der_oid_to_dotted_decimal_test
// Feeds DER elements into the decoder: a directed set covering every status
// and the arc extremes, then random well-formed object identifiers mixed with
// cut, restarted and malformed elements, under three tag settings and three
// idling patterns. The checker beside the block compares every character.
// ----------------------------------------------------------------------------
module der_oid_to_dotted_decimal_test;
    timeunit 1ns;
    timeprecision 1ps;

    import doid_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 12;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;
    logic [7:0] cur_tag;
    int         src_idle;
    int         sink_idle;
    int         fail_count;
    int         pending;
    int         cycles = 0;

    doid_in_if  in_ch ();
    doid_out_if out_ch ();

    der_oid_to_dotted_decimal u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    doid_text_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_bytes      (in_ch),
        .i_text       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** der_oid_to_dotted_decimal: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end

    task automatic send_beat(input logic [7:0] b, input logic f, input logic l);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= f;
        in_ch.last_byte  <= l;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic send_element(input logic [7:0] el[$], input logic end_mark);
        for (int i = 0; i < el.size(); i++) begin
            send_beat(el[i], i == 0, end_mark && (i == el.size() - 1));
        end
    endtask

    // Waits until every expected character has come, then lets the parser
    // drain bytes that produce no text.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_tag(input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_tag = v;
    endtask

    task automatic build_oid_element(output logic [7:0] el[$]);
        logic [7:0] body[$];
        int         arcs;
        int         nb;
        int         form;
        body.push_back(8'($urandom_range(255)));
        arcs = $urandom_range(4, 1);
        for (int i = 0; i < arcs; i++) begin
            nb = ($urandom_range(3) == 0) ? $urandom_range(5, 3) : $urandom_range(2, 1);
            for (int j = 1; j < nb; j++) body.push_back(8'h80 | 8'($urandom_range(127)));
            body.push_back(8'($urandom_range(127)));
        end
        // Now and then the content ends in the middle of a sub-identifier.
        if ($urandom_range(9) == 0) begin
            body[body.size() - 1] = body[body.size() - 1] | 8'h80;
        end
        el.delete();
        el.push_back(cur_tag);
        form = $urandom_range(3);
        if (form == 2) begin
            el.push_back(8'h81);
        end else if (form == 3) begin
            nb = $urandom_range(4, 2);
            el.push_back(8'h80 | 8'(nb));
            for (int j = 1; j < nb; j++) el.push_back(8'h00);
        end
        el.push_back(8'(body.size()));
        foreach (body[k]) el.push_back(body[k]);
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(3, 1)) el.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic run_random_elements(input int item_goal);
        logic [7:0] el[$];
        int         items;
        int         kind;
        int         cut;
        items = 0;
        while (items < item_goal) begin
            kind = $urandom_range(99);
            build_oid_element(el);
            if (kind < 62) begin
                send_element(el, 1'b1);
            end else if (kind < 72) begin
                cut = $urandom_range(el.size() - 1, 1);
                while (el.size() > cut) void'(el.pop_back());
                send_element(el, 1'b1);
            end else if (kind < 78) begin
                el[0] = cur_tag ^ 8'($urandom_range(255, 1));
                send_element(el, 1'b1);
            end else if (kind < 84) begin
                el.delete();
                el.push_back(cur_tag);
                if ($urandom_range(1) == 1) begin
                    el.push_back(8'h80 | 8'($urandom_range(127, 5)));
                    el.push_back(8'($urandom_range(255)));
                end else begin
                    // A four-byte length far beyond what the buffer holds.
                    el.push_back(8'h84);
                    el.push_back(8'($urandom_range(255, 1)));
                    repeat ($urandom_range(7, 3)) el.push_back(8'($urandom_range(255)));
                end
                send_element(el, 1'b1);
            end else if (kind < 90) begin
                el.delete();
                el.push_back(cur_tag);
                case ($urandom_range(3))
                    0: el.push_back(8'($urandom_range(1)));
                    1: el.push_back(8'h80);
                    2: begin
                        el.push_back(8'h81);
                        el.push_back(8'($urandom_range(1)));
                    end
                    default: begin
                        el.push_back(8'h84);
                        repeat (3) el.push_back(8'h00);
                        el.push_back(8'($urandom_range(1)));
                    end
                endcase
                if ($urandom_range(1) == 1) el.push_back(8'($urandom_range(255)));
                send_element(el, 1'($urandom_range(1)));
            end else if (kind < 95) begin
                // Cut short with no end mark; the next element restarts.
                cut = $urandom_range(el.size() - 1, 1);
                while (el.size() > cut) void'(el.pop_back());
                send_element(el, 1'b0);
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    send_beat(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
                end
                el.delete();
            end
            items += el.size();
        end
    endtask

    initial begin
        logic [7:0] el[$];
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_data         <= 8'h00;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= 8'h00;
        in_ch.first_byte <= 1'b0;
        in_ch.last_byte  <= 1'b0;
        cur_tag   = TAG_RESET;
        src_idle  = 21;
        sink_idle = 61;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1.2.840 in short form.
        el = {8'h06, 8'h03, 8'h2a, 8'h86, 8'h48};
        send_element(el, 1'b1);
        // Wrong tag, then a byte outside any element.
        el = {8'h07, 8'h00};
        send_element(el, 1'b1);
        // Long-form count of five.
        el = {8'h06, 8'h85};
        send_element(el, 1'b1);
        // Content of one byte, with the buffer ending on the length.
        el = {8'h06, 8'h01};
        send_element(el, 1'b1);
        // Long form with a count of zero.
        el = {8'h06, 8'h80};
        send_element(el, 1'b1);
        // Buffer ends on the tag.
        el = {8'h06};
        send_element(el, 1'b1);
        // First byte 0xff, then a sub-identifier that never ends.
        el = {8'h06, 8'h02, 8'hff, 8'h81};
        send_element(el, 1'b1);
        // 0.0.4294967295: the widest sub-identifier.
        el = {8'h06, 8'h06, 8'h00, 8'h8f, 8'hff, 8'hff, 8'hff, 8'h7f};
        send_element(el, 1'b1);
        settle();

        write_tag(8'hff);
        run_random_elements(155);
        settle();

        src_idle  = 61;
        sink_idle = 21;
        write_tag(8'h00);
        run_random_elements(155);
        settle();

        src_idle  = 0;
        sink_idle = 0;
        write_tag(8'($urandom_range(255)));
        run_random_elements(155);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("** der_oid_to_dotted_decimal: PASSED **");
        end else begin
            $display("** der_oid_to_dotted_decimal: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
design/doid_pkg.sv
design/doid_in_if.sv
design/doid_out_if.sv
design/doid_front.sv
design/doid_queue.sv
design/doid_back.sv
design/der_oid_to_dotted_decimal.sv
tb/doid_text_checker.sv
tb/der_oid_to_dotted_decimal_test.sv
